// ----- rtl/msit_pkg.sv -----
// shared constants and types of the multi-slot interval timer
`timescale 1ns / 1ps
`default_nettype none

package msit_pkg;

  // default size of the slot table
  localparam int SLOTS_DEF = 16;
  // slot fields are 4 bits wide, so at most this many slots are usable
  localparam int MAX_RES   = 16;
  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 32;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_START  = 3'd1,
    KIND_STOP   = 3'd2,
    KIND_TOGGLE = 3'd3,
    KIND_SET    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    EV_FIRED   = 3'd0,
    EV_STARTED = 3'd1,
    EV_FULL    = 3'd2,
    EV_BAD     = 3'd3,
    EV_DONE    = 3'd4
  } ev_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/msit_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module msit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/multi_slot_interval_timer.sv -----
// top level of the multi-slot interval timer: slot table, tick scanner, result register
`timescale 1ns / 1ps
`default_nettype none

// multi-slot interval timer
// in_* stream carries one command beat: in_tuser is the command kind (tick, start,
//   stop, toggle, set interval), in_tdata the slot, flags and interval
// out_* stream carries result beats; out_tlast marks the final beat of a command
// intervals and deadlines live in two small rams (one write, one registered read),
//   allocated and running flags in flip-flops
// non-tick commands: their single result is in the output register on the next cycle;
//   one command per cycle while results drain
// tick: the count advances, then the scanner streams the slots through the rams,
//   one slot per cycle unless stalled, writing back the grown deadline of each slot
//   that fires; it covers USABLE slots, the lesser of SLOTS and 16, and the next
//   command is taken only after the final beat of the tick has been loaded
// a fired result is held back until the next slot fires or the scan ends, so that tlast
//   can go on the final one; if nothing fires a single done beat is sent
// when the receiver stalls and another slot fires, the scanner stops on that slot and
//   resumes once the output register is free; nothing is dropped
// reset clears the count, all flags and the output valid bit; interval and
//   deadline entries are only used after a start has written them

module multi_slot_interval_timer #(
  parameter int SLOTS = msit_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // slot[3:0], new_handle[4], interval_value[36:5],
                                      // start_now[37], zero[39:38]
  input  wire logic [2:0]  in_tuser,  // kind[2:0]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata, // slot_out[3:0], zero[7:4]
  output logic [2:0]       out_tuser, // event_res[2:0]
  output logic             out_tlast  // last
);

  localparam int USABLE = (SLOTS < msit_pkg::MAX_RES) ? SLOTS : msit_pkg::MAX_RES;
  localparam int IDXW   = $clog2(USABLE);
  localparam int SW     = msit_pkg::SLOT_W;
  localparam int TW     = msit_pkg::TIME_W;
  localparam logic [IDXW:0] USABLE_I = (IDXW+1)'(USABLE);
  localparam logic [SW:0]   USABLE_S = (SW+1)'(USABLE);

  // input beat fields
  msit_pkg::kind_t  in_kind;
  logic [SW-1:0]    in_slot;
  logic             in_new;
  logic [TW-1:0]    in_ival;
  logic             in_now;
  logic             in_acc;

  assign in_kind = msit_pkg::kind_t'(in_tuser);
  assign in_slot = in_tdata[3:0];
  assign in_new  = in_tdata[4];
  assign in_ival = in_tdata[36:5];
  assign in_now  = in_tdata[37];

  // control state
  msit_pkg::state_t state_r, state_nxt;
  logic [TW-1:0]     now_r, now_nxt;
  logic [USABLE-1:0] in_use_r, in_use_nxt;
  logic [USABLE-1:0] running_r, running_nxt;
  logic [IDXW:0]     rd_idx_r, rd_idx_nxt;   // next slot to read
  logic              chk_vld_r, chk_vld_nxt; // ram data valid for chk_idx_r
  logic [IDXW-1:0]   chk_idx_r, chk_idx_nxt;
  logic              pend_vld_r, pend_vld_nxt; // fired beat held back for tlast
  logic [IDXW-1:0]   pend_idx_r, pend_idx_nxt;

  // output register
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [SW-1:0]    out_slot_r, out_slot_nxt;
  msit_pkg::ev_t    out_ev_r, out_ev_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_free;

  // result to load this cycle
  logic             emit;
  logic [SW-1:0]    emit_slot;
  msit_pkg::ev_t    emit_ev;
  logic             emit_last;

  // ram ports
  logic              iv_we, dl_we, ram_re;
  logic [IDXW-1:0]   waddr, raddr;
  logic [TW-1:0]     dl_wdata;
  logic [TW-1:0]     iv_q, dl_q;

  // decode helpers
  logic [IDXW-1:0]   sidx;
  logic              slot_ok;
  logic              free_any;
  logic [IDXW-1:0]   free_idx;
  logic              fire;
  logic              stall;

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == msit_pkg::ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign sidx    = in_slot[IDXW-1:0];
  assign slot_ok = ({1'b0, in_slot} < USABLE_S) && in_use_r[sidx];

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = USABLE - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_any = 1'b1;
        free_idx = IDXW'(i);
      end
    end
  end

  // slot under check fires when live and its deadline is strictly below the count
  assign fire  = chk_vld_r && in_use_r[chk_idx_r] && running_r[chk_idx_r] && (dl_q < now_r);
  // a second firing slot needs the held beat to leave first
  assign stall = fire && pend_vld_r && !out_free;

  always_comb begin
    state_nxt    = state_r;
    now_nxt      = now_r;
    in_use_nxt   = in_use_r;
    running_nxt  = running_r;
    rd_idx_nxt   = rd_idx_r;
    chk_vld_nxt  = chk_vld_r;
    chk_idx_nxt  = chk_idx_r;
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;

    emit      = 1'b0;
    emit_slot = '0;
    emit_ev   = msit_pkg::EV_DONE;
    emit_last = 1'b1;

    iv_we    = 1'b0;
    dl_we    = 1'b0;
    ram_re   = 1'b0;
    waddr    = sidx;
    raddr    = rd_idx_r[IDXW-1:0];
    dl_wdata = now_r;

    case (state_r)
      msit_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            msit_pkg::KIND_TICK: begin
              now_nxt      = now_r + 1'b1;
              rd_idx_nxt   = '0;
              chk_vld_nxt  = 1'b0;
              pend_vld_nxt = 1'b0;
              state_nxt    = msit_pkg::ST_SCAN;
            end
            msit_pkg::KIND_START: begin
              emit = 1'b1;
              if (in_new) begin
                if (free_any) begin
                  in_use_nxt[free_idx]  = 1'b1;
                  running_nxt[free_idx] = 1'b1;
                  iv_we     = 1'b1;
                  dl_we     = 1'b1;
                  waddr     = free_idx;
                  dl_wdata  = in_now ? now_r : now_r + in_ival;
                  emit_slot = SW'(free_idx);
                  emit_ev   = msit_pkg::EV_STARTED;
                end else begin
                  emit_ev = msit_pkg::EV_FULL;
                end
              end else if (!slot_ok) begin
                emit_slot = in_slot;
                emit_ev   = msit_pkg::EV_BAD;
              end else begin
                iv_we     = 1'b1;
                emit_slot = in_slot;
                // a paused slot resumes from the current count
                if (!running_r[sidx]) begin
                  running_nxt[sidx] = 1'b1;
                  dl_we             = 1'b1;
                end
              end
            end
            msit_pkg::KIND_STOP: begin
              emit      = 1'b1;
              emit_slot = in_slot;
              if (!slot_ok) begin
                emit_ev = msit_pkg::EV_BAD;
              end else begin
                in_use_nxt[sidx]  = 1'b0;
                running_nxt[sidx] = 1'b0;
              end
            end
            msit_pkg::KIND_TOGGLE: begin
              emit      = 1'b1;
              emit_slot = in_slot;
              if (!slot_ok) begin
                emit_ev = msit_pkg::EV_BAD;
              end else begin
                running_nxt[sidx] = !running_r[sidx];
                dl_we             = !running_r[sidx];
              end
            end
            msit_pkg::KIND_SET: begin
              emit      = 1'b1;
              emit_slot = in_slot;
              if (!slot_ok) begin
                emit_ev = msit_pkg::EV_BAD;
              end else begin
                iv_we = (in_ival != '0);
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      msit_pkg::ST_SCAN: begin
        waddr    = chk_idx_r;
        dl_wdata = dl_q + iv_q;
        if (!stall) begin
          if (fire) begin
            dl_we        = 1'b1;
            pend_vld_nxt = 1'b1;
            pend_idx_nxt = chk_idx_r;
            if (pend_vld_r) begin
              emit      = 1'b1;
              emit_slot = SW'(pend_idx_r);
              emit_ev   = msit_pkg::EV_FIRED;
              emit_last = 1'b0;
            end
          end
          if (rd_idx_r < USABLE_I) begin
            ram_re      = 1'b1;
            chk_vld_nxt = 1'b1;
            chk_idx_nxt = rd_idx_r[IDXW-1:0];
            rd_idx_nxt  = rd_idx_r + 1'b1;
          end else begin
            chk_vld_nxt = 1'b0;
            if (!chk_vld_r) begin
              state_nxt = msit_pkg::ST_FIN;
            end
          end
        end
      end
      msit_pkg::ST_FIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_vld_r) begin
            emit_slot = SW'(pend_idx_r);
            emit_ev   = msit_pkg::EV_FIRED;
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = msit_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = msit_pkg::ST_IDLE;
      end
    endcase
  end

  // output register loads only when free, which every emit path guarantees
  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_slot_nxt   = out_slot_r;
    out_ev_nxt     = out_ev_r;
    out_last_nxt   = out_last_r;
    if (emit) begin
      out_tvalid_nxt = 1'b1;
      out_slot_nxt   = emit_slot;
      out_ev_nxt     = emit_ev;
      out_last_nxt   = emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= msit_pkg::ST_IDLE;
      now_r        <= '0;
      in_use_r     <= '0;
      running_r    <= '0;
      rd_idx_r     <= '0;
      chk_vld_r    <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      now_r        <= now_nxt;
      in_use_r     <= in_use_nxt;
      running_r    <= running_nxt;
      rd_idx_r     <= rd_idx_nxt;
      chk_vld_r    <= chk_vld_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_slot_r <= out_slot_nxt;
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
  end

  // interval table
  msit_ram #(
    .WIDTH (TW),
    .DEPTH (USABLE)
  ) u_iv_ram (
    .clk   (clk),
    .we    (iv_we),
    .waddr (waddr),
    .wdata (in_ival),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (iv_q)
  );

  // deadline table
  msit_ram #(
    .WIDTH (TW),
    .DEPTH (USABLE)
  ) u_dl_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (waddr),
    .wdata (dl_wdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (dl_q)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_slot_r};
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;

  // a slot can only run while allocated
  a_run_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (running_r & ~in_use_r) == '0)
    else $error("running slot not allocated");

  // a tick advances the count by exactly one
  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == msit_pkg::KIND_TICK) |=> (now_r == $past(now_r) + 1'b1))
    else $error("count did not advance on tick");

  // the scanner never reads the entry it is writing back
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_re && dl_we) |-> (raddr != waddr))
    else $error("read and write-back hit the same slot");

  // no fired beat is left behind once the scan is over
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msit_pkg::ST_IDLE) |-> !pend_vld_r)
    else $error("held fired beat in idle");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// testbench of the multi-slot interval timer: directed table, random commands, beat checker
`timescale 1ns / 1ps

module tb;

  localparam int USABLE   = (msit_pkg::SLOTS_DEF < msit_pkg::MAX_RES) ?
                            msit_pkg::SLOTS_DEF : msit_pkg::MAX_RES;
  localparam int PLAN_LEN = 24;
  localparam int N_RANDOM = 245;
  localparam int LIMIT    = 400000;
  // a tick scans every slot and drains up to sixteen beats, so allow well over that
  localparam int SETTLE   = 60;

  // one command as it travels on the input stream
  typedef struct packed {
    msit_pkg::kind_t kind;
    logic [3:0]      slot;
    logic            new_handle;
    logic [31:0]     ival;
    logic            start_now;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic [3:0]    slot;
    msit_pkg::ev_t ev;
    logic          last;
  } beat_t;

  // directed row: a command, how often it is repeated, and an optional written-in result
  typedef struct packed {
    msit_pkg::kind_t kind;
    logic [3:0]      slot;
    logic            new_handle;
    logic [31:0]     ival;
    logic            start_now;
    logic [4:0]      reps;
    logic            typed;
    logic [3:0]      want_slot;
    msit_pkg::ev_t   want_ev;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // slot[3:0], new_handle[4], interval_value[36:5], start_now[37]
  logic [2:0]  in_tuser;   // kind[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // slot_out[3:0]
  logic [2:0]  out_tuser;  // event_res[2:0]
  logic        out_tlast;

  multi_slot_interval_timer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow copy of the slot table and tick count
  logic        slot_used   [USABLE];
  logic        slot_live   [USABLE];
  logic [31:0] slot_period [USABLE];
  logic [31:0] slot_due    [USABLE];
  logic [31:0] tick_now;

  beat_t step_beats[$];     // beats caused by the command just accepted
  beat_t awaited_beats[$];  // beats still owed by the block, oldest first

  // when set, neither side idles
  bit calm;

  int errors;
  int cmds_sent;
  int ticks_sent;
  int beats_seen;
  int fired_seen;
  int full_seen;
  int bad_seen;
  int cycles;

  row_t plan [PLAN_LEN];

  function automatic beat_t beat(input int slot, input msit_pkg::ev_t ev, input logic last);
    beat_t b;
    b.slot = slot[3:0];
    b.ev   = ev;
    b.last = last;
    return b;
  endfunction

  // apply one command to the shadow table and list the beats it causes
  function automatic void advance_timer(input cmd_t c);
    int    i;
    int    free_slot;
    logic  known;
    beat_t b;
    step_beats.delete();
    known     = slot_used[c.slot];
    free_slot = -1;
    for (i = USABLE - 1; i >= 0; i--)
      if (!slot_used[i]) free_slot = i;
    case (c.kind)
      msit_pkg::KIND_TICK: begin
        tick_now = tick_now + 32'd1;
        for (i = 0; i < USABLE; i++) begin
          // strict unsigned compare, deadline wraps at 32 bits
          if (slot_used[i] && slot_live[i] && slot_due[i] < tick_now) begin
            step_beats.push_back(beat(i, msit_pkg::EV_FIRED, 1'b0));
            slot_due[i] = slot_due[i] + slot_period[i];
          end
        end
        if (step_beats.size() == 0) begin
          step_beats.push_back(beat(0, msit_pkg::EV_DONE, 1'b1));
        end else begin
          b = step_beats.pop_back();
          b.last = 1'b1;
          step_beats.push_back(b);
        end
      end
      msit_pkg::KIND_START: begin
        if (c.new_handle) begin
          if (free_slot < 0) begin
            step_beats.push_back(beat(0, msit_pkg::EV_FULL, 1'b1));
          end else begin
            slot_used[free_slot]   = 1'b1;
            slot_live[free_slot]   = 1'b1;
            slot_period[free_slot] = c.ival;
            slot_due[free_slot]    = c.start_now ? tick_now : tick_now + c.ival;
            step_beats.push_back(beat(free_slot, msit_pkg::EV_STARTED, 1'b1));
          end
        end else if (!known) begin
          step_beats.push_back(beat(c.slot, msit_pkg::EV_BAD, 1'b1));
        end else begin
          slot_period[c.slot] = c.ival;
          // a paused slot resumes from now, a running one keeps its deadline
          if (!slot_live[c.slot]) begin
            slot_live[c.slot] = 1'b1;
            slot_due[c.slot]  = tick_now;
          end
          step_beats.push_back(beat(c.slot, msit_pkg::EV_DONE, 1'b1));
        end
      end
      msit_pkg::KIND_STOP: begin
        if (!known) begin
          step_beats.push_back(beat(c.slot, msit_pkg::EV_BAD, 1'b1));
        end else begin
          slot_used[c.slot] = 1'b0;
          slot_live[c.slot] = 1'b0;
          step_beats.push_back(beat(c.slot, msit_pkg::EV_DONE, 1'b1));
        end
      end
      msit_pkg::KIND_TOGGLE: begin
        if (!known) begin
          step_beats.push_back(beat(c.slot, msit_pkg::EV_BAD, 1'b1));
        end else begin
          slot_live[c.slot] = !slot_live[c.slot];
          if (slot_live[c.slot]) slot_due[c.slot] = tick_now;
          step_beats.push_back(beat(c.slot, msit_pkg::EV_DONE, 1'b1));
        end
      end
      msit_pkg::KIND_SET: begin
        if (!known) begin
          step_beats.push_back(beat(c.slot, msit_pkg::EV_BAD, 1'b1));
        end else begin
          // a zero interval leaves the old one in place
          if (c.ival != 32'd0) slot_period[c.slot] = c.ival;
          step_beats.push_back(beat(c.slot, msit_pkg::EV_DONE, 1'b1));
        end
      end
      default: begin
        step_beats.push_back(beat(0, msit_pkg::EV_DONE, 1'b1));
      end
    endcase
  endfunction

  // random command: mostly aimed at allocated slots with short intervals so that slots keep firing
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   r;
    int   i;
    int   live_list[$];
    r = $urandom_range(99);
    if (r < 36)      c.kind = msit_pkg::KIND_TICK;
    else if (r < 60) c.kind = msit_pkg::KIND_START;
    else if (r < 72) c.kind = msit_pkg::KIND_STOP;
    else if (r < 84) c.kind = msit_pkg::KIND_TOGGLE;
    else             c.kind = msit_pkg::KIND_SET;
    for (i = 0; i < USABLE; i++)
      if (slot_used[i]) live_list.push_back(i);
    c.slot = 4'($urandom_range(15));
    if (live_list.size() != 0 && $urandom_range(99) < 80)
      c.slot = 4'(live_list[$urandom_range(live_list.size() - 1)]);
    c.new_handle = ($urandom_range(99) < 70);
    r = $urandom_range(99);
    if (r < 65)      c.ival = $urandom_range(6);
    else if (r < 90) c.ival = $urandom;
    else if (r < 95) c.ival = '1;
    else             c.ival = 32'd0;
    c.start_now = 1'($urandom_range(1));
    return c;
  endfunction

  // present one command, hold it until accepted, then book its beats
  task automatic issue(input cmd_t c, input bit typed, input beat_t want);
    while (!calm && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.kind;
    in_tdata  <= {2'b00, c.start_now, c.ival, c.new_handle, c.slot};
    do @(posedge clk); while (!in_tready);
    advance_timer(c);
    // written-in rows still move the shadow table, but their own beat is the one checked
    if (typed) begin
      awaited_beats.push_back(want);
    end else begin
      foreach (step_beats[k]) awaited_beats.push_back(step_beats[k]);
    end
    cmds_sent++;
    if (c.kind == msit_pkg::KIND_TICK) ticks_sent++;
    @(negedge clk);
  endtask

  // receiver back-pressure, changed at the falling edge
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 37);
  end

  // result checker: every accepted beat against the oldest booked one
  always @(posedge clk) begin
    beat_t got;
    beat_t exp_b;
    if (rst_n && out_tvalid && out_tready) begin
      got.slot = out_tdata[3:0];
      got.ev   = msit_pkg::ev_t'(out_tuser);
      got.last = out_tlast;
      beats_seen++;
      if (got.ev == msit_pkg::EV_FIRED) fired_seen++;
      if (got.ev == msit_pkg::EV_FULL)  full_seen++;
      if (got.ev == msit_pkg::EV_BAD)   bad_seen++;
      if (awaited_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat slot %0d ev %0d last %0b", $time,
                 got.slot, got.ev, got.last);
      end else begin
        exp_b = awaited_beats.pop_front();
        if (got.slot !== exp_b.slot || got.ev !== exp_b.ev || got.last !== exp_b.last) begin
          errors++;
          $display("%0t: mismatch, expected slot %0d ev %0d last %0b, got slot %0d ev %0d last %0b",
                   $time, exp_b.slot, exp_b.ev, exp_b.last, got.slot, got.ev, got.last);
        end
      end
    end
  end

  // watchdog on the cycle count
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout with %0d beats outstanding", $time, awaited_beats.size());
    $display("** multi_slot_interval_timer: FAILED **");
    $finish;
  end

  initial begin
    cmd_t  c;
    beat_t w;
    int    n;
    int    r;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    calm       = 1'b0;
    errors     = 0;
    cmds_sent  = 0;
    ticks_sent = 0;
    beats_seen = 0;
    fired_seen = 0;
    full_seen  = 0;
    bad_seen   = 0;
    tick_now   = '0;
    for (n = 0; n < USABLE; n++) begin
      slot_used[n]   = 1'b0;
      slot_live[n]   = 1'b0;
      slot_period[n] = '0;
      slot_due[n]    = '0;
    end

    // directed part: command fields, then repeats, typed flag and written-in result
    plan = '{
      // first tick after reset: nothing allocated
      '{msit_pkg::KIND_TICK,   4'd0,  1'b0, 32'd0,        1'b0,
        5'd1,  1'b1, 4'd0,  msit_pkg::EV_DONE},
      // commands naming slots that were never allocated
      '{msit_pkg::KIND_SET,    4'd3,  1'b0, 32'd5,        1'b0,
        5'd1,  1'b1, 4'd3,  msit_pkg::EV_BAD},
      '{msit_pkg::KIND_STOP,   4'd15, 1'b1, 32'd0,        1'b0,
        5'd1,  1'b1, 4'd15, msit_pkg::EV_BAD},
      '{msit_pkg::KIND_TOGGLE, 4'd0,  1'b0, 32'd0,        1'b0,
        5'd1,  1'b1, 4'd0,  msit_pkg::EV_BAD},
      // kind outside the command set changes nothing
      '{msit_pkg::kind_t'(3'd5), 4'd6, 1'b1, 32'd4,       1'b1,
        5'd1,  1'b1, 4'd0,  msit_pkg::EV_DONE},
      // zero interval starting now, slot field ignored on a new start
      '{msit_pkg::KIND_START,  4'd9,  1'b1, 32'd0,        1'b1,
        5'd1,  1'b1, 4'd0,  msit_pkg::EV_STARTED},
      // largest interval: the deadline wraps round to zero
      '{msit_pkg::KIND_START,  4'd0,  1'b1, 32'hFFFFFFFF, 1'b0,
        5'd1,  1'b1, 4'd1,  msit_pkg::EV_STARTED},
      '{msit_pkg::KIND_START,  4'd0,  1'b1, 32'd2,        1'b0,
        5'd1,  1'b1, 4'd2,  msit_pkg::EV_STARTED},
      '{msit_pkg::KIND_TICK,   4'd0,  1'b0, 32'd0,        1'b0,
        5'd1,  1'b0, 4'd0,  msit_pkg::EV_DONE},
      // pause, zero set ignored, real set, restart resumes the paused slot
      '{msit_pkg::KIND_TOGGLE, 4'd1,  1'b0, 32'd0,        1'b0,
        5'd1,  1'b0, 4'd0,  msit_pkg::EV_DONE},
      '{msit_pkg::KIND_SET,    4'd0,  1'b0, 32'd0,        1'b0,
        5'd1,  1'b0, 4'd0,  msit_pkg::EV_DONE},
      '{msit_pkg::KIND_SET,    4'd0,  1'b0, 32'd3,        1'b0,
        5'd1,  1'b0, 4'd0,  msit_pkg::EV_DONE},
      '{msit_pkg::KIND_START,  4'd1,  1'b0, 32'd1,        1'b1,
        5'd1,  1'b0, 4'd0,  msit_pkg::EV_DONE},
      '{msit_pkg::KIND_TICK,   4'd0,  1'b0, 32'd0,        1'b0,
        5'd1,  1'b0, 4'd0,  msit_pkg::EV_DONE},
      // fill every remaining slot, then ask for one more
      '{msit_pkg::KIND_START,  4'd0,  1'b1, 32'd1,        1'b1,
        5'd13, 1'b0, 4'd0,  msit_pkg::EV_DONE},
      '{msit_pkg::KIND_START,  4'd0,  1'b1, 32'd7,        1'b0,
        5'd1,  1'b1, 4'd0,  msit_pkg::EV_FULL},
      // full table firing at once
      '{msit_pkg::KIND_TICK,   4'd0,  1'b0, 32'd0,        1'b0,
        5'd2,  1'b0, 4'd0,  msit_pkg::EV_DONE},
      // restart of a running slot keeps its deadline
      '{msit_pkg::KIND_START,  4'd4,  1'b0, 32'hAAAA5555, 1'b0,
        5'd1,  1'b0, 4'd0,  msit_pkg::EV_DONE},
      '{msit_pkg::KIND_TOGGLE, 4'd15, 1'b0, 32'd0,        1'b0,
        5'd2,  1'b0, 4'd0,  msit_pkg::EV_DONE},
      // restart of a freed slot
      '{msit_pkg::KIND_STOP,   4'd0,  1'b0, 32'd0,        1'b0,
        5'd1,  1'b0, 4'd0,  msit_pkg::EV_DONE},
      '{msit_pkg::KIND_START,  4'd0,  1'b0, 32'd9,        1'b1,
        5'd1,  1'b1, 4'd0,  msit_pkg::EV_BAD},
      '{msit_pkg::KIND_TICK,   4'd0,  1'b0, 32'd0,        1'b0,
        5'd1,  1'b0, 4'd0,  msit_pkg::EV_DONE},
      '{msit_pkg::KIND_STOP,   4'd15, 1'b0, 32'd0,        1'b0,
        5'd1,  1'b0, 4'd0,  msit_pkg::EV_DONE},
      '{msit_pkg::KIND_START,  4'd7,  1'b1, 32'h7FFFFFFF, 1'b1,
        5'd1,  1'b0, 4'd0,  msit_pkg::EV_DONE}
    };

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (n = 0; n < PLAN_LEN; n++) begin
      c.kind       = plan[n].kind;
      c.slot       = plan[n].slot;
      c.new_handle = plan[n].new_handle;
      c.ival       = plan[n].ival;
      c.start_now  = plan[n].start_now;
      w            = beat(plan[n].want_slot, plan[n].want_ev, 1'b1);
      for (r = 0; r < plan[n].reps; r++) issue(c, plan[n].typed, w);
    end

    // random part, with a stretch where neither side idles
    for (n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 120 && n < 180);
      issue(random_cmd(), 1'b0, w);
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("ran %0d commands (%0d ticks), checked %0d beats", cmds_sent, ticks_sent, beats_seen);
    $display("  of them %0d fired, %0d table full, %0d bad slot", fired_seen, full_seen, bad_seen);
    if (errors == 0) begin
      $display("** multi_slot_interval_timer: PASSED **");
    end else begin
      $display("** multi_slot_interval_timer: FAILED **");
    end
    $finish;
  end

endmodule
